@@ hdl/sorted_key_set_macros.svh @@
// Assertion helpers for the sorted key set sequencer.
`ifndef SORTED_KEY_SET_MACROS_SVH
`define SORTED_KEY_SET_MACROS_SVH

// Checked property, ignored while reset is held.
`define SKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property, also during reset.
`define SKS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/sks_pkg.sv @@
package sks_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed field widths on the ports
  localparam int FUNC_W        = 2;
  localparam int KEY_FIELD_W   = 32;
  localparam int POS_W         = 6;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_FIND   = 2'd0,
    FN_ADD    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_REM_AT = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_EXEC
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DEL_GE,
    OP_DEL_POS
  } cell_op_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic     latch;
    cell_op_t op;
  } cell_ctl_t;

endpackage

@@ hdl/sks_cell.sv @@
module sks_cell
  import sks_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int CNT_W     = 7,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [KEY_WIDTH-1:0] key_b,
  input  logic [CNT_W-1:0]     count,
  input  logic [POS_W-1:0]     pos,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic                 left_ge,
  input  logic [KEY_WIDTH-1:0] right_key,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic                 ge_o,
  output logic                 eq_o
);

  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 ge_r, eq_r, atpos_r;
  logic                 used;

  // This slot holds a live key
  assign used = int'(count) > IDX;

  // Latch the compare flags for the current word
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      ge_r    <= !(used && (key_r < key_b));
      eq_r    <= used && (key_r == key_b);
      atpos_r <= IDX >= int'(pos);
    end
  end

  // Shift or hold the stored key
  always_comb begin
    key_nxt = key_r;
    unique case (ctl.op)
      OP_HOLD: key_nxt = key_r;
      OP_INSERT: begin
        if (ge_r) key_nxt = left_ge ? left_key : key_b;
      end
      OP_DEL_GE: begin
        if (ge_r) key_nxt = right_key;
      end
      OP_DEL_POS: begin
        if (atpos_r) key_nxt = right_key;
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o = key_r;
  assign ge_o  = ge_r;
  assign eq_o  = eq_r;

endmodule

@@ hdl/sks_seq.sv @@
module sks_seq
  import sks_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  func_t                in_func,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [POS_W-1:0]     in_pos,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 out_found,
  output status_t              out_status,
  output logic [CNT_W-1:0]     out_count,
  input  logic [CAPACITY-1:0]  eq_vec,
  output cell_ctl_t            ctl,
  output logic [KEY_WIDTH-1:0] key_q,
  output logic [POS_W-1:0]     pos_q,
  output logic [CNT_W-1:0]     count_q
);

  `include "sorted_key_set_macros.svh"

  state_t               state_r, state_nxt;
  func_t                func_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [POS_W-1:0]     pos_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 any_eq_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 found_r, found_nxt;
  status_t              status_r, status_nxt;
  logic                 go;

  // Result slot free, or freed in this cycle
  assign go = !out_valid_r || out_tready;

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the word, reduce the match flags, hold the result
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_func;
      key_r  <= in_key;
      pos_r  <= in_pos;
    end
    if (state_r == S_RED) any_eq_r <= |eq_vec;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  // Next state, cell command and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    found_nxt     = found_r;
    status_nxt    = status_r;
    ctl.latch     = 1'b0;
    ctl.op        = OP_HOLD;
    in_tready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid) state_nxt = S_CMP;
      end
      S_CMP: begin
        ctl.latch = 1'b1;
        state_nxt = S_RED;
      end
      S_RED: state_nxt = S_EXEC;
      S_EXEC: begin
        if (go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          status_nxt    = ST_OK;
          unique case (func_r)
            FN_FIND: begin
              found_nxt  = any_eq_r;
              status_nxt = any_eq_r ? ST_OK : ST_NOT_FOUND;
            end
            FN_ADD: begin
              if (int'(count_r) >= CAPACITY) begin
                status_nxt = ST_FULL;
              end else begin
                ctl.op    = OP_INSERT;
                count_nxt = count_r + 1'b1;
              end
            end
            FN_REMOVE: begin
              if (any_eq_r) begin
                found_nxt = 1'b1;
                ctl.op    = OP_DEL_GE;
                count_nxt = count_r - 1'b1;
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            FN_REM_AT: begin
              if (int'(pos_r) < int'(count_r)) begin
                ctl.op    = OP_DEL_POS;
                count_nxt = count_r - 1'b1;
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_found  = found_r;
  assign out_status = status_r;
  assign out_count  = count_r;
  assign key_q      = key_r;
  assign pos_q      = pos_r;
  assign count_q    = count_r;

  `SKS_ASSERT(a_count_cap, int'(count_r) <= CAPACITY, "entry count above capacity")
  `SKS_ASSERT(a_accept_cmp, (in_tvalid && in_tready) |=> (state_r == S_CMP), "accept did not start compare")
  `SKS_ASSERT(a_count_exec, (state_r != S_EXEC) |=> $stable(count_r), "count moved outside execute")
  `SKS_ASSERT(a_out_rise, $rose(out_valid_r) |-> ($past(state_r) == S_EXEC), "result without execute")
  `SKS_ASSERT(a_full_hold, (state_r == S_EXEC && go && func_r == FN_ADD && int'(count_r) == CAPACITY) |=> (int'(count_r) == CAPACITY), "add to a full table changed count")

endmodule

@@ hdl/sorted_key_set.sv @@
// Sorted key set: ascending key table held in a row of cells, one key per cell.
// Each accepted word passes the steps accept, compare in every cell, match reduce and
// shift of the row, and a new word is taken only after the previous one is executed;
// the execute step waits while the previous result is unread.
// Reset clears the entry count and handshake state; key cells are not cleared.
module sorted_key_set
  import sks_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // key[31:0], position[37:32], zero pad
  input  logic [1:0]  in_tuser,  // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // found[0], status[2:1], entry_count[9:3], zero pad
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_ctl_t            ctl;
  logic [KEY_WIDTH-1:0] key_in, key_q;
  logic [POS_W-1:0]     pos_q;
  logic [CNT_W-1:0]     count_q, out_count;
  logic                 out_found;
  status_t              out_status;
  func_t                func_in;
  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]  cell_ge;
  logic [CAPACITY-1:0]  eq_vec;

  // Unpack the input word
  assign key_in  = KEY_WIDTH'(in_tdata[KEY_FIELD_W-1:0]);
  assign func_in = func_t'(in_tuser);

  sks_seq #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (func_in),
    .in_key    (key_in),
    .in_pos    (in_tdata[KEY_FIELD_W+POS_W-1:KEY_FIELD_W]),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_found (out_found),
    .out_status(out_status),
    .out_count (out_count),
    .eq_vec    (eq_vec),
    .ctl       (ctl),
    .key_q     (key_q),
    .pos_q     (pos_q),
    .count_q   (count_q)
  );

  // Row of key cells, each linked to its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] lkey, rkey;
    logic                 lge;
    if (i == 0) begin : g_first
      assign lkey = cell_key[i];
      assign lge  = 1'b0;
    end else begin : g_mid
      assign lkey = cell_key[i-1];
      assign lge  = cell_ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rkey = cell_key[i];
    end else begin : g_inner
      assign rkey = cell_key[i+1];
    end
    sks_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .CNT_W    (CNT_W),
      .IDX      (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key_b    (key_q),
      .count    (count_q),
      .pos      (pos_q),
      .left_key (lkey),
      .left_ge  (lge),
      .right_key(rkey),
      .key_o    (cell_key[i]),
      .ge_o     (cell_ge[i]),
      .eq_o     (eq_vec[i])
    );
  end

  // Pack the result word
  assign out_tdata = {6'b0, ENTRY_COUNT_W'(out_count), out_status, out_found};

endmodule
